[sv/sactag_pkg.sv]
// shared constants, codes and word types of the cache tag store
package sactag_pkg;

  // geometry
  localparam int WAYS          = 4;
  localparam int SETS          = 64;
  localparam int ADDRESS_WIDTH = 48;

  // field widths fixed by the interface
  localparam int ADDR_W     = 48;
  localparam int TAG_W      = ADDR_W;
  localparam int CNT_W      = 32;
  localparam int LFSR_W     = 16;
  localparam int OUT_WAY_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int POLICY_W   = 2;
  localparam int SB_W       = 3;
  localparam int OB_W       = 4;
  localparam int SHAMT_W    = 5;

  // derived sizes
  localparam int SET_LOG = $clog2(SETS + 1) - 1;
  localparam int SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EFF_AW  = (ADDRESS_WIDTH < ADDR_W) ? ADDRESS_WIDTH : ADDR_W;

  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_AW);
  localparam logic [OB_W-1:0]   MAX_OFFSET = OB_W'(12);

  // random replacement generator
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // replacement policy codes
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LFU  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RAND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  // configuration reset values
  localparam logic [POLICY_W-1:0] POLICY_RST      = POL_LRU;
  localparam logic [SB_W-1:0]     SET_BITS_RST    = 3'd6;
  localparam logic [OB_W-1:0]     OFFSET_BITS_RST = 4'd6;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 evicted;
    logic                 writeback;
    logic [ADDR_W-1:0]    victim_address;
  } out_word_t;

  // configuration after saturation
  typedef struct packed {
    logic [POLICY_W-1:0] policy;
    logic [SB_W-1:0]     sb;
    logic [OB_W-1:0]     ob;
  } cfg_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][CNT_W-1:0] cnt_row_t;
  typedef logic [WAYS-1:0]            flag_row_t;

  // one set as seen by the lookup stage
  typedef struct packed {
    tag_row_t  tag;
    cnt_row_t  stamp;
    cnt_row_t  uses;
    flag_row_t valid;
    flag_row_t dirty;
  } look_t;

  // update of one line
  typedef struct packed {
    logic             we;
    logic             fill;
    logic             dirty_we;
    logic [WAY_W-1:0] way;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stamp;
    logic [CNT_W-1:0] uses;
    logic             dirty;
  } upd_t;

endpackage

[sv/sactag_cfg.sv]
// configuration registers with saturation of the address split
module sactag_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sactag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sactag_pkg::CFG_DATA_W-1:0] cfg_data,
  output sactag_pkg::cfg_t                  cfg
);
  import sactag_pkg::*;

  logic [POLICY_W-1:0] policy_r;
  logic [SB_W-1:0]     set_bits_r;
  logic [OB_W-1:0]     offset_bits_r;

  assign cfg_ready = rst_n;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= POLICY_RST;
      set_bits_r    <= SET_BITS_RST;
      offset_bits_r <= OFFSET_BITS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLICY:      policy_r      <= cfg_data[POLICY_W-1:0];
        CFG_SET_BITS:    set_bits_r    <= cfg_data[SB_W-1:0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[OB_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp split to what the set array and block size allow
  always_comb begin
    cfg.policy = policy_r;
    cfg.sb     = (32'(set_bits_r) > SET_LOG) ? SB_W'(SET_LOG) : set_bits_r;
    cfg.ob     = (offset_bits_r > MAX_OFFSET) ? MAX_OFFSET : offset_bits_r;
  end

endmodule

[sv/sactag_store.sv]
// per-way tag, stamp and use-count arrays plus valid and dirty flags
module sactag_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [sactag_pkg::SET_W-1:0] rd_set,
  input  logic [sactag_pkg::SET_W-1:0] look_set,
  input  sactag_pkg::upd_t             upd,
  output sactag_pkg::look_t            look
);
  import sactag_pkg::*;

  logic [TAG_W-1:0] tag_mem   [WAYS][SETS];
  logic [CNT_W-1:0] stamp_mem [WAYS][SETS];
  logic [CNT_W-1:0] uses_mem  [WAYS][SETS];

  tag_row_t tag_rd_r;
  cnt_row_t stamp_rd_r;
  cnt_row_t uses_rd_r;

  logic [SETS-1:0][WAYS-1:0] valid_r;
  logic [SETS-1:0][WAYS-1:0] dirty_r;

  // line arrays: one write and one registered read of a whole set per cycle
  always_ff @(posedge clk) begin
    if (upd.we) begin
      stamp_mem[upd.way][upd.set] <= upd.stamp;
      uses_mem[upd.way][upd.set]  <= upd.uses;
    end
    if (upd.fill) begin
      tag_mem[upd.way][upd.set] <= upd.tag;
    end
    if (rd_en) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_rd_r[w]   <= tag_mem[w][rd_set];
        stamp_rd_r[w] <= stamp_mem[w][rd_set];
        uses_rd_r[w]  <= uses_mem[w][rd_set];
      end
    end
  end

  // valid and dirty flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (upd.fill) begin
        valid_r[upd.set][upd.way] <= 1'b1;
      end
      if (upd.dirty_we) begin
        dirty_r[upd.set][upd.way] <= upd.dirty;
      end
    end
  end

  assign look.tag   = tag_rd_r;
  assign look.stamp = stamp_rd_r;
  assign look.uses  = uses_rd_r;
  assign look.valid = valid_r[look_set];
  assign look.dirty = dirty_r[look_set];

endmodule

[sv/sactag_repl.sv]
// victim choice for a full set: oldest stamp, fewest uses or random
module sactag_repl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sactag_pkg::POLICY_W-1:0] policy,
  input  sactag_pkg::cnt_row_t            stamp,
  input  sactag_pkg::cnt_row_t            uses,
  input  logic                            step,
  output logic [sactag_pkg::WAY_W-1:0]    victim_way
);
  import sactag_pkg::*;

  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_nxt;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  lfu_way;
  logic [WAY_W-1:0]  rand_way;

  // galois step, shifting right
  always_comb begin
    lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    rand_way = WAY_W'(lfsr_nxt % WAYS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (step) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // minimum search, lowest way wins ties
  always_comb begin
    lru_way = '0;
    lfu_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (stamp[w] < stamp[lru_way]) lru_way = WAY_W'(w);
      if (uses[w] < uses[lfu_way])   lfu_way = WAY_W'(w);
    end
  end

  always_comb begin
    case (policy)
      POL_LFU:  victim_way = lfu_way;
      POL_RAND: victim_way = rand_way;
      default:  victim_way = lru_way;
    endcase
  end

endmodule

[sv/set_assoc_cache_tag_store_core.sv]
// top level of the set-associative cache tag store
// an accepted word is registered into the lookup stage, and its result is registered from there and strobed
// no new word is accepted while the lookup stage holds one, because of the read-then-update of the line arrays
// busy is high for the one cycle in which the accepted set is compared and written back, and while reset is asserted
// reset: synchronous active low; all lines invalid and clean, access clock zero, lfsr one
// results are strobed for one cycle and cannot be stalled by the receiver
module set_assoc_cache_tag_store_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  sactag_pkg::in_word_t              in_data,
  output logic                              out_valid,
  output sactag_pkg::out_word_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sactag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sactag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sactag_pkg::*;

  cfg_t  cfg;
  look_t look;
  upd_t  upd;

  logic accept;

  // lookup stage registers
  logic              stage_valid_r;
  logic              req_op_r;
  logic [TAG_W-1:0]  req_tag_r;
  logic [SET_W-1:0]  req_set_r;
  logic [OB_W-1:0]   req_ob_r;
  logic [SB_W-1:0]   req_sb_r;
  logic [CNT_W-1:0]  access_clock_r;

  // result registers
  logic      out_valid_r;
  out_word_t out_data_r;

  // split of the incoming address
  logic [ADDR_W-1:0]  addr_m;
  logic [SHAMT_W-1:0] tag_shamt;
  logic [SET_W:0]     set_mask_wide;
  logic [SET_W-1:0]   set_nxt;
  logic [TAG_W-1:0]   tag_nxt;

  // lookup results
  logic [WAYS-1:0]   hit_vec;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic              full;
  logic [WAY_W-1:0]  repl_way;
  logic [WAY_W-1:0]  way_sel;
  logic [SHAMT_W-1:0] req_shamt;
  logic [ADDR_W-1:0] victim_addr;
  logic [CNT_W-1:0]  uses_inc;
  logic              rand_step;
  out_word_t         out_nxt;

  assign busy   = stage_valid_r | ~rst_n;
  assign accept = start & ~busy;

  sactag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // address split with the current configuration
  always_comb begin
    addr_m        = in_data.address & ADDR_MASK;
    tag_shamt     = SHAMT_W'(cfg.ob) + SHAMT_W'(cfg.sb);
    set_mask_wide = ((SET_W + 1)'(1) << cfg.sb) - (SET_W + 1)'(1);
    set_nxt       = SET_W'(addr_m >> cfg.ob) & set_mask_wide[SET_W-1:0];
    tag_nxt       = addr_m >> tag_shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= in_data.opcode;
      req_tag_r <= tag_nxt;
      req_set_r <= set_nxt;
      req_ob_r  <= cfg.ob;
      req_sb_r  <= cfg.sb;
    end
  end

  sactag_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_set   (set_nxt),
    .look_set (req_set_r),
    .upd      (upd),
    .look     (look)
  );

  // tag compare across all ways, first hit and first free way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = look.valid[w] && (look.tag[w] == req_tag_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w])     hit_way = WAY_W'(w);
      if (!look.valid[w]) inv_way = WAY_W'(w);
    end
    hit  = |hit_vec;
    full = &look.valid;
  end

  assign rand_step = stage_valid_r & ~hit & full & (cfg.policy == POL_RAND);

  sactag_repl u_repl (
    .clk        (clk),
    .rst_n      (rst_n),
    .policy     (cfg.policy),
    .stamp      (look.stamp),
    .uses       (look.uses),
    .step       (rand_step),
    .victim_way (repl_way)
  );

  // way choice, victim rebuild and line update
  always_comb begin
    way_sel     = hit ? hit_way : (full ? repl_way : inv_way);
    req_shamt   = SHAMT_W'(req_ob_r) + SHAMT_W'(req_sb_r);
    victim_addr = ((look.tag[repl_way] << req_shamt)
                  | (ADDR_W'(req_set_r) << req_ob_r)) & ADDR_MASK;
    uses_inc    = (look.uses[hit_way] == '1) ? look.uses[hit_way]
                                             : look.uses[hit_way] + CNT_W'(1);

    upd.we       = stage_valid_r;
    upd.fill     = stage_valid_r & ~hit;
    upd.dirty_we = stage_valid_r & (~hit | (req_op_r == OP_WRITE));
    upd.way      = way_sel;
    upd.set      = req_set_r;
    upd.tag      = req_tag_r;
    upd.stamp    = access_clock_r;
    upd.uses     = hit ? uses_inc : CNT_W'(1);
    upd.dirty    = (req_op_r == OP_WRITE);

    out_nxt.hit            = hit;
    out_nxt.way            = OUT_WAY_W'(way_sel);
    out_nxt.evicted        = ~hit & full;
    out_nxt.writeback      = ~hit & full & look.dirty[repl_way];
    out_nxt.victim_address = (~hit & full) ? victim_addr : '0;
  end

  // access clock and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_clock_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= stage_valid_r;
      if (stage_valid_r) begin
        access_clock_r <= access_clock_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every accepted word gives its result strobe after its lookup stage
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> ##1 out_valid)
    else $error("accepted word gave no result");

  // a result never overlaps the lookup of the next word
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !stage_valid_r)
    else $error("result strobe overlaps a lookup");

  // a hit never replaces a line
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_data.hit |-> !out_data.evicted)
    else $error("hit reported an eviction");

  // writeback and victim address only with an eviction
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && !out_data.evicted |->
                   !out_data.writeback && (out_data.victim_address == '0))
    else $error("victim reported without eviction");

  // the random generator only moves on a full-set miss
  assert property (@(posedge clk) disable iff (!rst_n)
                   rand_step |-> stage_valid_r && full && !hit)
    else $error("random generator stepped outside a full-set miss");

endmodule
